[src/sfk_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and operand tables for the skeleton forward kinematics block.
// No dependencies; the other files, sfk_ram apart, refer to this package by scoped names.
package sfk_pkg;

  localparam int MaxJoints = 256;
  localparam int StoreDepth = (MaxJoints < 256) ? MaxJoints : 256;
  localparam int AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int QueueDepth = 2;
  localparam int One = 16384;

  // operand sources of the shared multiplier
  localparam logic [3:0] SRC_P0  = 4'd0;
  localparam logic [3:0] SRC_P1  = 4'd1;
  localparam logic [3:0] SRC_P2  = 4'd2;
  localparam logic [3:0] SRC_P3  = 4'd3;
  localparam logic [3:0] SRC_L0  = 4'd4;
  localparam logic [3:0] SRC_L1  = 4'd5;
  localparam logic [3:0] SRC_L2  = 4'd6;
  localparam logic [3:0] SRC_L3  = 4'd7;
  localparam logic [3:0] SRC_V0  = 4'd8;
  localparam logic [3:0] SRC_V1  = 4'd9;
  localparam logic [3:0] SRC_V2  = 4'd10;
  localparam logic [3:0] SRC_D2  = 4'd11;
  localparam logic [3:0] SRC_C2X = 4'd12;
  localparam logic [3:0] SRC_C2Y = 4'd13;
  localparam logic [3:0] SRC_C2Z = 4'd14;
  localparam logic [3:0] SRC_K   = 4'd15;

  localparam logic [1:0] OP_NOP = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [1:0] op;
  } term_t;

  typedef struct packed {
    logic              is_root;
    logic [7:0]        parent_index;
    logic [3:0][15:0]  local_q;
    logic [2:0][31:0]  rest;
    logic [2:0][31:0]  root;
    logic [7:0]        joint;
    logic [31:0]       frame;
    logic              last;
    logic              bad;
  } job_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [7:0]  joint_number;
    logic [31:0] frame_number;
    logic        last_of_frame;
    logic        bad_parent;
  } res_t;

  function automatic term_t mk(input logic [3:0] a, input logic [3:0] b, input logic [1:0] op);
    term_t t;
    t.a = a;
    t.b = b;
    t.op = op;
    return t;
  endfunction

  // Hamilton product parent * local, one component per group
  function automatic term_t qp_term(input logic [1:0] g, input logic [1:0] s);
    term_t t;
    case ({g, s})
      4'd0:  t = mk(SRC_P3, SRC_L0, OP_ADD);
      4'd1:  t = mk(SRC_P0, SRC_L3, OP_ADD);
      4'd2:  t = mk(SRC_P1, SRC_L2, OP_ADD);
      4'd3:  t = mk(SRC_P2, SRC_L1, OP_SUB);
      4'd4:  t = mk(SRC_P3, SRC_L1, OP_ADD);
      4'd5:  t = mk(SRC_P0, SRC_L2, OP_SUB);
      4'd6:  t = mk(SRC_P1, SRC_L3, OP_ADD);
      4'd7:  t = mk(SRC_P2, SRC_L0, OP_ADD);
      4'd8:  t = mk(SRC_P3, SRC_L2, OP_ADD);
      4'd9:  t = mk(SRC_P0, SRC_L1, OP_ADD);
      4'd10: t = mk(SRC_P1, SRC_L0, OP_SUB);
      4'd11: t = mk(SRC_P2, SRC_L3, OP_ADD);
      4'd12: t = mk(SRC_P3, SRC_L3, OP_ADD);
      4'd13: t = mk(SRC_P0, SRC_L0, OP_SUB);
      4'd14: t = mk(SRC_P1, SRC_L1, OP_SUB);
      4'd15: t = mk(SRC_P2, SRC_L2, OP_SUB);
      default: t = mk(SRC_P0, SRC_P0, OP_NOP);
    endcase
    return t;
  endfunction

  // rotate by the parent: dot, cross x/y/z, k, then result x/y/z
  function automatic term_t rot_term(input logic [2:0] g, input logic [1:0] s);
    term_t t;
    case ({g, s})
      5'd0:  t = mk(SRC_P0, SRC_V0, OP_ADD);
      5'd1:  t = mk(SRC_P1, SRC_V1, OP_ADD);
      5'd2:  t = mk(SRC_P2, SRC_V2, OP_ADD);
      5'd4:  t = mk(SRC_P1, SRC_V2, OP_ADD);
      5'd5:  t = mk(SRC_P2, SRC_V1, OP_SUB);
      5'd8:  t = mk(SRC_P2, SRC_V0, OP_ADD);
      5'd9:  t = mk(SRC_P0, SRC_V2, OP_SUB);
      5'd12: t = mk(SRC_P0, SRC_V1, OP_ADD);
      5'd13: t = mk(SRC_P1, SRC_V0, OP_SUB);
      5'd16: t = mk(SRC_P3, SRC_P3, OP_ADD);
      5'd17: t = mk(SRC_P0, SRC_P0, OP_SUB);
      5'd18: t = mk(SRC_P1, SRC_P1, OP_SUB);
      5'd19: t = mk(SRC_P2, SRC_P2, OP_SUB);
      5'd20: t = mk(SRC_D2, SRC_P0, OP_ADD);
      5'd21: t = mk(SRC_V0, SRC_K, OP_ADD);
      5'd22: t = mk(SRC_C2X, SRC_P3, OP_ADD);
      5'd24: t = mk(SRC_D2, SRC_P1, OP_ADD);
      5'd25: t = mk(SRC_V1, SRC_K, OP_ADD);
      5'd26: t = mk(SRC_C2Y, SRC_P3, OP_ADD);
      5'd28: t = mk(SRC_D2, SRC_P2, OP_ADD);
      5'd29: t = mk(SRC_V2, SRC_K, OP_ADD);
      5'd30: t = mk(SRC_C2Z, SRC_P3, OP_ADD);
      default: t = mk(SRC_P0, SRC_P0, OP_NOP);
    endcase
    return t;
  endfunction

  // round to nearest, ties away from zero, then drop 14 fraction bits
  function automatic logic signed [71:0] rshr14(input logic signed [71:0] x);
    logic signed [71:0] b;
    b = x + (x[71] ? 72'sd8191 : 72'sd8192);
    return b >>> 14;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

endpackage

[src/skeleton_forward_kinematics_core.sv]
`timescale 1ns / 1ps
// Skeleton forward kinematics core: front end, request queue, compute engine.
// The engine handles one joint at a time and takes no new request until it is idle again;
// a root or bad-parent joint skips the product and rotation, and a child with a zero local
// rotation skips the product. The shared 38x34 multiplier, the 32-step square root and the
// 15-step divider run serially for each normalize.
// Reset (rst, synchronous): joint_count = 1, counters zero, queue and result empty.
module skeleton_forward_kinematics_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               is_root,
  input  logic [7:0]         parent_index,
  input  logic signed [15:0] local_qx,
  input  logic signed [15:0] local_qy,
  input  logic signed [15:0] local_qz,
  input  logic signed [15:0] local_qw,
  input  logic signed [31:0] rest_x,
  input  logic signed [31:0] rest_y,
  input  logic signed [31:0] rest_z,
  input  logic signed [31:0] root_x,
  input  logic signed [31:0] root_y,
  input  logic signed [31:0] root_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [7:0]         joint_number,
  output logic [31:0]        frame_number,
  output logic               last_of_frame,
  output logic               bad_parent
);

  logic          q_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  sfk_pkg::job_t q_job;
  sfk_pkg::job_t q_head;
  sfk_pkg::res_t res;

  assign full = q_full;

  // front end: number the joint and classify it
  sfk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (q_full),
    .is_root      (is_root),
    .parent_index (parent_index),
    .local_qx     (local_qx),
    .local_qy     (local_qy),
    .local_qz     (local_qz),
    .local_qw     (local_qw),
    .rest_x       (rest_x),
    .rest_y       (rest_y),
    .rest_z       (rest_z),
    .root_x       (root_x),
    .root_y       (root_y),
    .root_z       (root_z),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // decouple the front end from the engine
  sfk_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty)
  );

  // engine with joint stores and the result register
  sfk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign pos_x         = res.pos_x;
  assign pos_y         = res.pos_y;
  assign pos_z         = res.pos_z;
  assign joint_number  = res.joint_number;
  assign frame_number  = res.frame_number;
  assign last_of_frame = res.last_of_frame;
  assign bad_parent    = res.bad_parent;

  // a bad parent always yields a zero position
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_parent) |-> (pos_x == 0 && pos_y == 0 && pos_z == 0))
    else $error("bad parent result with nonzero position");

  // the request queue is never full and empty at once
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("request queue full and empty together");

  // the engine only takes a request that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("request taken from an empty queue");

endmodule

[src/sfk_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfk_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr,
  input  logic [Width-1:0]                  wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr,
  output logic [Width-1:0]                  rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/sfk_front.sv]
`timescale 1ns / 1ps
// Front end: takes input items, numbers joints and frames, flags bad parents.
// Depends on sfk_pkg; feeds sfk_job_queue.
module sfk_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  input  logic               push,
  input  logic               full,
  input  logic               is_root,
  input  logic [7:0]         parent_index,
  input  logic signed [15:0] local_qx,
  input  logic signed [15:0] local_qy,
  input  logic signed [15:0] local_qz,
  input  logic signed [15:0] local_qw,
  input  logic signed [31:0] rest_x,
  input  logic signed [31:0] rest_y,
  input  logic signed [31:0] rest_z,
  input  logic signed [31:0] root_x,
  input  logic signed [31:0] root_y,
  input  logic signed [31:0] root_z,
  output logic               q_push,
  output sfk_pkg::job_t      q_job
);

  logic [8:0]  joint_count;
  logic [7:0]  joint_counter;
  logic [31:0] frame_counter;
  logic [8:0]  count_eff;
  logic        last;

  assign cfg_ready = 1'b1;
  assign q_push = push && !full;

  always_comb begin
    if (joint_count == 9'd0) begin
      count_eff = 9'd1;
    end else if (joint_count > 9'(sfk_pkg::StoreDepth)) begin
      count_eff = 9'(sfk_pkg::StoreDepth);
    end else begin
      count_eff = joint_count;
    end
  end

  assign last = ({1'b0, joint_counter} + 9'd1) >= count_eff;

  always_comb begin
    q_job.is_root      = is_root;
    q_job.parent_index = parent_index;
    q_job.local_q      = {local_qw, local_qz, local_qy, local_qx};
    q_job.rest         = {rest_z, rest_y, rest_x};
    q_job.root         = {root_z, root_y, root_x};
    q_job.joint        = joint_counter;
    q_job.frame        = frame_counter;
    q_job.last         = last;
    q_job.bad          = !is_root && (parent_index >= joint_counter);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count   <= 9'd1;
      joint_counter <= 8'd0;
      frame_counter <= 32'd0;
    end else begin
      if (cfg_valid) begin
        joint_count <= cfg_data;
      end
      // advance the joint number; wrap and bump the frame on the last joint
      if (q_push) begin
        if (last) begin
          joint_counter <= 8'd0;
          frame_counter <= frame_counter + 32'd1;
        end else begin
          joint_counter <= joint_counter + 8'd1;
        end
      end
    end
  end

endmodule

[src/sfk_job_queue.sv]
`timescale 1ns / 1ps
// Short request queue between the front end and the compute engine.
// Depends on sfk_pkg for the request type and depth.
module sfk_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfk_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output sfk_pkg::job_t head_job,
  output logic          empty
);

  localparam int PtrW = (sfk_pkg::QueueDepth > 1) ? $clog2(sfk_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(sfk_pkg::QueueDepth + 1);

  sfk_pkg::job_t entries [sfk_pkg::QueueDepth];
  logic [PtrW-1:0] wp;
  logic [PtrW-1:0] rp;
  logic [CntW-1:0] cnt;
  logic            do_push;
  logic            do_pop;

  assign full     = cnt == CntW'(sfk_pkg::QueueDepth);
  assign empty    = cnt == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entries[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PtrW'(sfk_pkg::QueueDepth - 1)) ? '0 : wp + PtrW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PtrW'(sfk_pkg::QueueDepth - 1)) ? '0 : rp + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CntW'(1);
      end
    end
  end

endmodule

[src/sfk_back.sv]
`timescale 1ns / 1ps
// Compute engine: normalize, quaternion product, rotate, joint stores, result register.
// Depends on sfk_pkg and sfk_ram.
module sfk_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  sfk_pkg::job_t q_head,
  output logic          q_pop,
  output logic          res_empty,
  input  logic          res_pop,
  output sfk_pkg::res_t res
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ    = 4'd1;
  localparam logic [3:0] ST_SQCHK = 4'd2;
  localparam logic [3:0] ST_SQRT  = 4'd3;
  localparam logic [3:0] ST_DLD   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_DST   = 4'd6;
  localparam logic [3:0] ST_NEND  = 4'd7;
  localparam logic [3:0] ST_VSET  = 4'd8;
  localparam logic [3:0] ST_MAC   = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;
  localparam logic [3:0] ST_APPLY = 4'd11;
  localparam logic [3:0] ST_WR    = 4'd12;

  logic [3:0]  state;
  logic        out_valid;
  sfk_pkg::job_t job;
  logic        mode;
  logic        prog;
  logic        lzero;
  logic [2:0]  grp;
  logic [1:0]  slot;
  logic        ph;
  logic [1:0]  ci;
  logic [4:0]  sqcnt;
  logic [3:0]  dcnt;

  logic signed [31:0] na [4];
  logic signed [15:0] n [4];
  logic signed [15:0] lq [4];
  logic [63:0] s;
  logic [63:0] sq_v;
  logic [63:0] sq_r;
  logic [63:0] sq_bit;
  logic [63:0] sqrt_t;
  logic [46:0] rem;
  logic [46:0] dvs;
  logic [14:0] quo;
  logic [14:0] qc;
  logic [31:0] na_mag;

  logic signed [32:0] v [3];
  logic signed [37:0] d2;
  logic signed [37:0] c2 [3];
  logic signed [17:0] k;
  logic signed [71:0] acc;
  logic signed [71:0] prod;
  logic signed [71:0] rnd;
  logic signed [31:0] pos [3];

  logic signed [37:0] mul_a;
  logic signed [33:0] mul_b;
  sfk_pkg::term_t     tm;

  logic [63:0] rot_rd;
  logic [95:0] pos_rd;
  logic [95:0] rest_rd;
  logic signed [15:0] pr [4];
  logic signed [31:0] ppos [3];
  logic signed [31:0] prest [3];
  logic signed [31:0] ppos_sel;
  logic signed [43:0] psum;
  logic signed [31:0] psat;
  logic        rd_en;
  logic        wr_en;
  logic [1:0]  cidx;
  logic [1:0]  pidx;

  for (genvar i = 0; i < 4; i++) begin : g_pr
    assign pr[i] = $signed(rot_rd[16*i +: 16]);
  end
  for (genvar i = 0; i < 3; i++) begin : g_pp
    assign ppos[i]  = $signed(pos_rd[32*i +: 32]);
    assign prest[i] = $signed(rest_rd[32*i +: 32]);
  end

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign rd_en     = q_pop;
  assign wr_en     = (state == ST_WR) && (!out_valid || res_pop);
  assign res_empty = !out_valid;

  sfk_ram #(.Width(64), .Depth(sfk_pkg::StoreDepth)) u_rot_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (job.joint[sfk_pkg::AddrW-1:0]),
    .wr_data ({n[3], n[2], n[1], n[0]}),
    .rd_en   (rd_en),
    .rd_addr (q_head.parent_index[sfk_pkg::AddrW-1:0]),
    .rd_data (rot_rd)
  );

  sfk_ram #(.Width(96), .Depth(sfk_pkg::StoreDepth)) u_pos_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (job.joint[sfk_pkg::AddrW-1:0]),
    .wr_data ({pos[2], pos[1], pos[0]}),
    .rd_en   (rd_en),
    .rd_addr (q_head.parent_index[sfk_pkg::AddrW-1:0]),
    .rd_data (pos_rd)
  );

  sfk_ram #(.Width(96), .Depth(sfk_pkg::StoreDepth)) u_rest_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (job.joint[sfk_pkg::AddrW-1:0]),
    .wr_data (job.rest),
    .rd_en   (rd_en),
    .rd_addr (q_head.parent_index[sfk_pkg::AddrW-1:0]),
    .rd_data (rest_rd)
  );

  assign tm     = prog ? sfk_pkg::rot_term(grp, slot) : sfk_pkg::qp_term(grp[1:0], slot);
  assign na_mag = sfk_pkg::mag32((state == ST_SQ) ? na[slot] : na[ci]);
  assign sqrt_t = sq_r + sq_bit;
  assign dvs    = 47'(sq_r[31:0]) << dcnt;
  assign qc     = (quo > 15'(sfk_pkg::One)) ? 15'(sfk_pkg::One) : quo;
  assign cidx   = 2'(grp - 3'd1);
  assign pidx   = 2'(grp - 3'd5);

  // operand select for the shared multiplier
  always_comb begin
    if (state == ST_SQ) begin
      mul_a = 38'($signed({1'b0, na_mag}));
      mul_b = 34'($signed({1'b0, na_mag}));
    end else begin
      case (tm.a)
        sfk_pkg::SRC_P0:  mul_a = 38'(pr[0]);
        sfk_pkg::SRC_P1:  mul_a = 38'(pr[1]);
        sfk_pkg::SRC_P2:  mul_a = 38'(pr[2]);
        sfk_pkg::SRC_P3:  mul_a = 38'(pr[3]);
        sfk_pkg::SRC_L0:  mul_a = 38'(lq[0]);
        sfk_pkg::SRC_L1:  mul_a = 38'(lq[1]);
        sfk_pkg::SRC_L2:  mul_a = 38'(lq[2]);
        sfk_pkg::SRC_L3:  mul_a = 38'(lq[3]);
        sfk_pkg::SRC_V0:  mul_a = 38'(v[0]);
        sfk_pkg::SRC_V1:  mul_a = 38'(v[1]);
        sfk_pkg::SRC_V2:  mul_a = 38'(v[2]);
        sfk_pkg::SRC_D2:  mul_a = d2;
        sfk_pkg::SRC_C2X: mul_a = c2[0];
        sfk_pkg::SRC_C2Y: mul_a = c2[1];
        sfk_pkg::SRC_C2Z: mul_a = c2[2];
        default:          mul_a = 38'(k);
      endcase
      case (tm.b)
        sfk_pkg::SRC_P0: mul_b = 34'(pr[0]);
        sfk_pkg::SRC_P1: mul_b = 34'(pr[1]);
        sfk_pkg::SRC_P2: mul_b = 34'(pr[2]);
        sfk_pkg::SRC_P3: mul_b = 34'(pr[3]);
        sfk_pkg::SRC_L0: mul_b = 34'(lq[0]);
        sfk_pkg::SRC_L1: mul_b = 34'(lq[1]);
        sfk_pkg::SRC_L2: mul_b = 34'(lq[2]);
        sfk_pkg::SRC_L3: mul_b = 34'(lq[3]);
        sfk_pkg::SRC_V0: mul_b = 34'(v[0]);
        sfk_pkg::SRC_V1: mul_b = 34'(v[1]);
        sfk_pkg::SRC_V2: mul_b = 34'(v[2]);
        sfk_pkg::SRC_K:  mul_b = 34'(k);
        default:         mul_b = '0;
      endcase
    end
  end

  // parent position plus rotated offset, saturated
  always_comb begin
    ppos_sel = ppos[pidx];
    psum = 44'(ppos_sel) + rnd[43:0];
    if (psum[43:31] == {13{psum[43]}}) begin
      psat = psum[31:0];
    end else begin
      psat = psum[43] ? 32'sh80000000 : 32'sh7fffffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job <= q_head;
            for (int i = 0; i < 4; i++) begin
              na[i] <= 32'($signed(q_head.local_q[i])) <<< 14;
            end
            mode  <= 1'b0;
            s     <= '0;
            slot  <= '0;
            ph    <= 1'b0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (!ph) begin
            prod <= mul_a * mul_b;
            ph   <= 1'b1;
          end else begin
            s    <= s + prod[63:0];
            ph   <= 1'b0;
            slot <= slot + 2'd1;
            if (slot == 2'd3) begin
              state <= ST_SQCHK;
            end
          end
        end
        ST_SQCHK: begin
          if (!mode) begin
            lzero <= s == '0;
          end
          if (s == '0) begin
            // zero vector: hold the identity
            n[0]  <= '0;
            n[1]  <= '0;
            n[2]  <= '0;
            n[3]  <= 16'(sfk_pkg::One);
            state <= ST_NEND;
          end else begin
            sq_v   <= s;
            sq_r   <= '0;
            sq_bit <= 64'd1 << 62;
            sqcnt  <= 5'd31;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_v >= sqrt_t) begin
            sq_v <= sq_v - sqrt_t;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sqcnt == '0) begin
            ci    <= '0;
            state <= ST_DLD;
          end else begin
            sqcnt <= sqcnt - 5'd1;
          end
        end
        ST_DLD: begin
          rem   <= 47'({na_mag, 14'b0}) + 47'(sq_r[31:1]);
          quo   <= '0;
          dcnt  <= 4'd14;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (rem >= dvs) begin
            rem       <= rem - dvs;
            quo[dcnt] <= 1'b1;
          end
          if (dcnt == '0) begin
            state <= ST_DST;
          end else begin
            dcnt <= dcnt - 4'd1;
          end
        end
        ST_DST: begin
          n[ci] <= na[ci][31] ? -$signed(16'(qc)) : $signed(16'(qc));
          if (ci == 2'd3) begin
            state <= ST_NEND;
          end else begin
            ci    <= ci + 2'd1;
            state <= ST_DLD;
          end
        end
        ST_NEND: begin
          if (!mode) begin
            for (int i = 0; i < 4; i++) begin
              lq[i] <= n[i];
            end
            if (job.is_root) begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= $signed(job.root[i]);
              end
              state <= ST_WR;
            end else if (job.bad) begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= '0;
              end
              state <= ST_WR;
            end else if (lzero) begin
              state <= ST_VSET;
            end else begin
              prog  <= 1'b0;
              grp   <= '0;
              slot  <= '0;
              ph    <= 1'b0;
              acc   <= '0;
              state <= ST_MAC;
            end
          end else begin
            state <= ST_VSET;
          end
        end
        ST_VSET: begin
          for (int i = 0; i < 3; i++) begin
            v[i] <= 33'($signed(job.rest[i])) - 33'(prest[i]);
          end
          prog  <= 1'b1;
          grp   <= '0;
          slot  <= '0;
          ph    <= 1'b0;
          acc   <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          if (!ph) begin
            prod <= mul_a * mul_b;
            ph   <= 1'b1;
          end else begin
            case (tm.op)
              sfk_pkg::OP_ADD: acc <= acc + prod;
              sfk_pkg::OP_SUB: acc <= acc - prod;
              default:         acc <= acc;
            endcase
            ph   <= 1'b0;
            slot <= slot + 2'd1;
            if (slot == 2'd3) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          rnd   <= sfk_pkg::rshr14(acc);
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          acc  <= '0;
          slot <= '0;
          ph   <= 1'b0;
          if (!prog) begin
            na[grp[1:0]] <= acc[31:0];
            if (grp == 3'd3) begin
              mode  <= 1'b1;
              s     <= '0;
              state <= ST_SQ;
            end else begin
              grp   <= grp + 3'd1;
              state <= ST_MAC;
            end
          end else begin
            case (grp)
              3'd0:             d2      <= {rnd[36:0], 1'b0};
              3'd1, 3'd2, 3'd3: c2[cidx] <= {rnd[36:0], 1'b0};
              3'd4:             k       <= rnd[17:0];
              default:          pos[pidx] <= psat;
            endcase
            if (grp == 3'd7) begin
              state <= ST_WR;
            end else begin
              grp   <= grp + 3'd1;
              state <= ST_MAC;
            end
          end
        end
        ST_WR: begin
          if (!out_valid || res_pop) begin
            out_valid         <= 1'b1;
            res.pos_x         <= pos[0];
            res.pos_y         <= pos[1];
            res.pos_z         <= pos[2];
            res.joint_number  <= job.joint;
            res.frame_number  <= job.frame;
            res.last_of_frame <= job.last;
            res.bad_parent    <= job.bad;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/skeleton_forward_kinematics_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for skeleton_forward_kinematics_core: queue-style request and
// result ports, a joint_count write channel, and a bit-exact pose predictor.
// Depends on sfk_pkg (res_t) and the core RTL only.
module skeleton_forward_kinematics_core_tb;

  localparam int  ONE_Q14     = 16384;
  localparam int  STORE_DEPTH = 256;
  localparam int  RAND_ITEMS  = 1150;
  localparam longint CYCLE_LIMIT = 3000000;

  // one joint request as the sender sees it
  typedef struct {
    logic        is_root;
    logic [7:0]  parent_index;
    logic signed [15:0] q [4];
    logic signed [31:0] rest [3];
    logic signed [31:0] root [3];
  } joint_req_t;

  typedef longint quat_wide_t [4];
  typedef int     quat_t [4];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic is_root = 1'b0;
  logic [7:0] parent_index = '0;
  logic signed [15:0] local_qx = '0, local_qy = '0, local_qz = '0, local_qw = '0;
  logic signed [31:0] rest_x = '0, rest_y = '0, rest_z = '0;
  logic signed [31:0] root_x = '0, root_y = '0, root_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [7:0] joint_number;
  logic [31:0] frame_number;
  logic last_of_frame, bad_parent;

  skeleton_forward_kinematics_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full),
    .is_root(is_root), .parent_index(parent_index),
    .local_qx(local_qx), .local_qy(local_qy), .local_qz(local_qz), .local_qw(local_qw),
    .rest_x(rest_x), .rest_y(rest_y), .rest_z(rest_z),
    .root_x(root_x), .root_y(root_y), .root_z(root_z),
    .empty(empty), .pop(pop),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .joint_number(joint_number), .frame_number(frame_number),
    .last_of_frame(last_of_frame), .bad_parent(bad_parent)
  );

  always #2 clk = ~clk;

  // ------------------------------------------------------------------
  // Pose predictor: own copy of the joint stores, counters and register
  // ------------------------------------------------------------------
  int      world_rot [STORE_DEPTH][4];
  int      world_pos [STORE_DEPTH][3];
  int      rest_pos  [STORE_DEPTH][3];
  int unsigned cur_joint;
  int unsigned cur_frame;
  int unsigned joints_per_frame;

  sfk_pkg::res_t expected_poses [$];
  joint_req_t    pending_joints [$];

  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  int  error_count  = 0;
  int  poses_checked = 0;
  int  bad_seen = 0;
  int  frames_seen = 0;
  longint cycle_count = 0;

  function automatic longint unsigned magnitude(input longint x);
    return (x < 0) ? longint'(0) - x : x;
  endfunction

  // round to nearest, ties away from zero, drop 14 fraction bits
  function automatic longint round_q14(input longint x);
    longint unsigned m;
    longint r;
    m = magnitude(x);
    r = longint'((m + 64'd8192) >> 14);
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void normalize_quat(input quat_wide_t a, output quat_t n);
    longint unsigned s;
    longint unsigned len;
    longint unsigned m;
    longint unsigned q;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m = magnitude(a[i]);
      s = s + m * m;
    end
    if (s == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0; n[3] = ONE_Q14;
      return;
    end
    len = int_sqrt(s);
    for (int i = 0; i < 4; i++) begin
      q = ((magnitude(a[i]) << 14) + len / 2) / len;
      if (q > ONE_Q14) q = ONE_Q14;
      n[i] = (a[i] < 0) ? -int'(q) : int'(q);
    end
  endfunction

  function automatic int sat32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  // compute the pose of one accepted joint and advance the counters
  function automatic sfk_pkg::res_t pose_joint(input joint_req_t r);
    sfk_pkg::res_t o;
    int unsigned cnt;
    int unsigned j;
    int unsigned p;
    logic bad, last, zero_q;
    quat_wide_t a;
    quat_t lq, rot;
    int pos [3];
    longint ux, uy, uz, w, bx, by, bz, bw, d, k, rr;
    longint v [3];
    longint c [3];
    longint u [3];
    cnt = (joints_per_frame == 0) ? 1 : joints_per_frame;
    if (cnt > STORE_DEPTH) cnt = STORE_DEPTH;
    j = cur_joint;
    p = 32'(r.parent_index);
    bad = !r.is_root && (p >= j);
    last = (j + 1 >= cnt);
    for (int i = 0; i < 4; i++) a[i] = longint'(r.q[i]) * ONE_Q14;
    normalize_quat(a, lq);
    if (r.is_root) begin
      rot = lq;
      for (int i = 0; i < 3; i++) pos[i] = r.root[i];
    end else if (bad) begin
      rot = lq;
      for (int i = 0; i < 3; i++) pos[i] = 0;
    end else begin
      ux = world_rot[p][0]; uy = world_rot[p][1]; uz = world_rot[p][2]; w = world_rot[p][3];
      bx = lq[0]; by = lq[1]; bz = lq[2]; bw = lq[3];
      zero_q = (r.q[0] == 0) && (r.q[1] == 0) && (r.q[2] == 0) && (r.q[3] == 0);
      if (zero_q) begin
        rot[0] = 0; rot[1] = 0; rot[2] = 0; rot[3] = ONE_Q14;
      end else begin
        a[0] = w * bx + ux * bw + uy * bz - uz * by;
        a[1] = w * by - ux * bz + uy * bw + uz * bx;
        a[2] = w * bz + ux * by - uy * bx + uz * bw;
        a[3] = w * bw - ux * bx - uy * by - uz * bz;
        normalize_quat(a, rot);
      end
      for (int i = 0; i < 3; i++) v[i] = longint'(r.rest[i]) - longint'(rest_pos[p][i]);
      u[0] = ux; u[1] = uy; u[2] = uz;
      d = round_q14(ux * v[0] + uy * v[1] + uz * v[2]);
      c[0] = round_q14(uy * v[2] - uz * v[1]);
      c[1] = round_q14(uz * v[0] - ux * v[2]);
      c[2] = round_q14(ux * v[1] - uy * v[0]);
      k = round_q14(w * w - (ux * ux + uy * uy + uz * uz));
      for (int i = 0; i < 3; i++) begin
        rr = round_q14(2 * d * u[i] + k * v[i] + 2 * w * c[i]);
        pos[i] = sat32(longint'(world_pos[p][i]) + rr);
      end
    end
    for (int i = 0; i < 4; i++) world_rot[j][i] = rot[i];
    for (int i = 0; i < 3; i++) begin
      world_pos[j][i] = pos[i];
      rest_pos[j][i] = r.rest[i];
    end
    o.pos_x = pos[0];
    o.pos_y = pos[1];
    o.pos_z = pos[2];
    o.joint_number = j[7:0];
    o.frame_number = cur_frame;
    o.last_of_frame = last;
    o.bad_parent = bad;
    if (last) begin
      cur_joint = 0;
      cur_frame = cur_frame + 1;
    end else begin
      cur_joint = j + 1;
    end
    return o;
  endfunction

  // ------------------------------------------------------------------
  // Driver: present pending joints, predict on each accepted request
  // ------------------------------------------------------------------
  joint_req_t on_bus;

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) expected_poses.insert(expected_poses.size(), pose_joint(on_bus));
      if ((!push || !full) && pending_joints.size() != 0 &&
          $urandom_range(99) >= snd_idle_pct) begin
        // load the next request; hold it until accepted
        on_bus = pending_joints.pop_front();
        push <= 1'b1;
        is_root <= on_bus.is_root;
        parent_index <= on_bus.parent_index;
        local_qx <= on_bus.q[0];
        local_qy <= on_bus.q[1];
        local_qz <= on_bus.q[2];
        local_qw <= on_bus.q[3];
        rest_x <= on_bus.rest[0];
        rest_y <= on_bus.rest[1];
        rest_z <= on_bus.rest[2];
        root_x <= on_bus.root[0];
        root_y <= on_bus.root[1];
        root_z <= on_bus.root[2];
      end else if (!push || !full) begin
        push <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: check each popped pose against the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_poses.size() == 0) begin
          $error("pose popped with nothing expected (joint %0d)", joint_number);
          error_count++;
        end else begin
          sfk_pkg::res_t e;
          e = expected_poses.pop_front();
          poses_checked++;
          if (bad_parent) bad_seen++;
          if (last_of_frame) frames_seen++;
          if (pos_x !== e.pos_x) begin
            $error("pos_x exp %0d got %0d", $signed(e.pos_x), pos_x); error_count++;
          end
          if (pos_y !== e.pos_y) begin
            $error("pos_y exp %0d got %0d", $signed(e.pos_y), pos_y); error_count++;
          end
          if (pos_z !== e.pos_z) begin
            $error("pos_z exp %0d got %0d", $signed(e.pos_z), pos_z); error_count++;
          end
          if (joint_number !== e.joint_number) begin
            $error("joint_number exp %0d got %0d", e.joint_number, joint_number);
            error_count++;
          end
          if (frame_number !== e.frame_number) begin
            $error("frame_number exp %0d got %0d", e.frame_number, frame_number);
            error_count++;
          end
          if (last_of_frame !== e.last_of_frame) begin
            $error("last_of_frame exp %0b got %0b", e.last_of_frame, last_of_frame);
            error_count++;
          end
          if (bad_parent !== e.bad_parent) begin
            $error("bad_parent exp %0b got %0b", e.bad_parent, bad_parent);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  int unsigned gen_joint;
  int unsigned gen_count;

  // advance the generator's own view of the joint counter
  task automatic queue_joint(input joint_req_t r);
    int unsigned cnt;
    cnt = (gen_count == 0) ? 1 : ((gen_count > STORE_DEPTH) ? STORE_DEPTH : gen_count);
    pending_joints.insert(pending_joints.size(), r);
    gen_joint = (gen_joint + 1 >= cnt) ? 0 : gen_joint + 1;
  endtask

  // drain everything, then write joint_count
  task automatic write_joint_count(input int unsigned value);
    while (pending_joints.size() != 0 || push || expected_poses.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    joints_per_frame = 32'(value[8:0]);
    gen_count = 32'(value[8:0]);
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(9) < 7) return 32'($signed($urandom_range(2097152)) - 1048576);
    return 32'($urandom);
  endfunction

  function automatic joint_req_t rand_joint(input int unsigned j);
    joint_req_t r;
    int sel;
    sel = $urandom_range(99);
    r.is_root = (j == 0) ? (sel < 92) : (sel < 7);
    if (j == 0 || sel >= 92 || sel < 7) r.parent_index = 8'($urandom);
    else r.parent_index = 8'($urandom_range(j - 1));
    if (j != 0 && sel >= 92) r.parent_index = 8'($urandom_range(255, j)); // broken hierarchy
    case ($urandom_range(9))
      0: for (int i = 0; i < 4; i++) r.q[i] = '0;
      1, 2: for (int i = 0; i < 4; i++) r.q[i] = 16'($urandom);
      default: for (int i = 0; i < 4; i++) r.q[i] = rand_comp();
    endcase
    for (int i = 0; i < 3; i++) begin
      r.rest[i] = rand_coord();
      r.root[i] = rand_coord();
    end
    return r;
  endfunction

  function automatic joint_req_t mk_joint(input logic root, input logic [7:0] par,
                                          input int qx, input int qy, input int qz,
                                          input int qw, input int rv, input int tv);
    joint_req_t r;
    r.is_root = root;
    r.parent_index = par;
    r.q[0] = 16'(qx); r.q[1] = 16'(qy); r.q[2] = 16'(qz); r.q[3] = 16'(qw);
    for (int i = 0; i < 3; i++) begin
      r.rest[i] = rv;
      r.root[i] = tv;
    end
    return r;
  endfunction

  int unsigned settings [6] = '{5, 256, 1, 511, 0, 23};

  initial begin
    cur_joint = 0;
    cur_frame = 0;
    joints_per_frame = 1;
    gen_joint = 0;
    gen_count = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero rotation, broken parents, root mid-frame
    snd_idle_pct = 35;
    rcv_idle_pct = 83;
    write_joint_count(8);
    queue_joint(mk_joint(1'b0, 8'd0, 0, 0, 0, ONE_Q14, 0, 0));           // parent not below joint
    queue_joint(mk_joint(1'b1, 8'd0, -32768, -32768, -32768, -32768,
                         32'sh80000000, 32'sh7fffffff));
    queue_joint(mk_joint(1'b0, 8'd0, 32767, 32767, 32767, 32767,
                         32'sh7fffffff, 0));
    queue_joint(mk_joint(1'b0, 8'd2, 0, 0, 0, 0, 32'sh80000000, 0));     // zero local rotation
    queue_joint(mk_joint(1'b0, 8'd255, 100, 0, 0, 0, 5, 5));             // parent far ahead
    write_joint_count(3);                                                // lower count mid-frame
    queue_joint(mk_joint(1'b1, 8'd7, 0, 0, 0, 0, 65536, -65536));        // root, zero rotation
    write_joint_count(0);
    queue_joint(mk_joint(1'b1, 8'd0, 11585, 0, 0, 11585, 1, 2));
    queue_joint(mk_joint(1'b0, 8'd0, 0, 16384, 0, 0, 3, 4));
    write_joint_count(4);
    queue_joint(mk_joint(1'b1, 8'd0, 0, 0, 16384, 0, 32'sh7fffffff, 32'sh7fffffff));
    queue_joint(mk_joint(1'b0, 8'd0, 8192, 8192, 8192, 8192, 32'sh80000000, 0));
    queue_joint(mk_joint(1'b0, 8'd1, -16384, 0, 0, 0, 32'sh7fffffff, 0));
    queue_joint(mk_joint(1'b0, 8'd2, 1, -1, 1, -1, 32'sh80000000, 0));
    queue_joint(mk_joint(1'b1, 8'd0, 0, 0, 0, 1, -32'sd1, -32'sd1));
    queue_joint(mk_joint(1'b0, 8'd0, 0, 0, 0, 16384, 32'sh7fffffff, 0));

    // random frames across several counts and idling mixes
    for (int s = 0; s < 6; s++) begin
      write_joint_count(settings[s]);
      gen_joint = cur_joint;
      snd_idle_pct = (s < 2) ? 35 : ((s < 4) ? 83 : 0);
      rcv_idle_pct = (s < 2) ? 83 : ((s < 4) ? 35 : 0);
      for (int n = 0; n < RAND_ITEMS / 6; n++) queue_joint(rand_joint(gen_joint));
    end

    while (pending_joints.size() != 0 || push || expected_poses.size() != 0)
      @(negedge clk);
    repeat (400) @(posedge clk);
    $display("checked %0d poses over %0d frames, %0d with a broken parent",
             poses_checked, frames_seen, bad_seen);
    $display("joint_count settings 8, 3, 0, 4, 5, 256, 1, 511, 0, 23 under mixed idling");
    if (error_count == 0 && expected_poses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
